### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

### hw/rtl/cmm_pkg.sv
`timescale 1ns / 1ps
package cmm_pkg;

   localparam int MAX_DIM = 8;
   localparam int IDX_W   = $clog2(MAX_DIM);
   localparam int DIM_W   = 4;
   localparam int ACC_W   = 40;

   // Configuration register indexes.
   localparam logic [1:0] CSR_LEFT_ROWS  = 2'd0;
   localparam logic [1:0] CSR_INNER_SIZE = 2'd1;
   localparam logic [1:0] CSR_RIGHT_COLS = 2'd2;

   localparam logic FUNC_LEFT  = 1'b0;
   localparam logic FUNC_RIGHT = 1'b1;

   typedef struct packed {
      logic               func;
      logic [2:0]         row_index;
      logic [2:0]         col_index;
      logic signed [15:0] value_re;
      logic signed [15:0] value_im;
      logic               load_last;
   } req_type;

   typedef struct packed {
      logic [2:0]               out_row;
      logic [2:0]               out_col;
      logic signed [ACC_W-1:0]  prod_re;
      logic signed [ACC_W-1:0]  prod_im;
      logic                     out_last;
   } rsp_type;

   // One left element travelling down the row of cells.
   typedef struct packed {
      logic               valid;
      logic signed [15:0] a_re;
      logic signed [15:0] a_im;
      logic [IDX_W-1:0]   k;
      logic [IDX_W-1:0]   row;
      logic               first;
      logic               lastk;
      logic               lastrow;
   } tok_type;

   // Right element write broadcast to the cells.
   typedef struct packed {
      logic               en;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic signed [15:0] re;
      logic signed [15:0] im;
   } rwr_type;

   // Clamp a dimension register to 1..MAX_DIM and return it minus one.
   function automatic logic [IDX_W-1:0] dim_m1(input logic [DIM_W-1:0] v);
      logic [IDX_W-1:0] r;
      if (v == '0) begin
         r = '0;
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = IDX_W'(MAX_DIM - 1);
      end else begin
         r = IDX_W'(v - 1'b1);
      end
      return r;
   endfunction

endpackage

### hw/rtl/cmm_cell.sv
`timescale 1ns / 1ps
module cmm_cell import cmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] col_id,
   input  logic [IDX_W-1:0] nc_m1,
   input  rwr_type          rwr,
   input  tok_type          tok_in,
   output tok_type          tok_out,
   output logic             done,
   output rsp_type          res
);

   // One column of the right matrix lives in this cell.
   logic signed [15:0] rre_ff [MAX_DIM];
   logic signed [15:0] rim_ff [MAX_DIM];

   tok_type tok_ff;
   logic signed [31:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff;
   logic done_ff;
   logic [IDX_W-1:0] row_ff;
   logic last_ff;

   logic signed [15:0] b_re, b_im;
   logic signed [32:0] term_re, term_im;
   logic signed [ACC_W-1:0] base_re, base_im;
   logic signed [ACC_W:0] sum_re, sum_im;
   logic signed [ACC_W-1:0] acc_re_in, acc_im_in;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   // Store right elements addressed to this column.
   always_ff @(posedge clock) begin
      if (rwr.en && rwr.col == col_id) begin
         rre_ff[rwr.row] <= rwr.re;
         rim_ff[rwr.row] <= rwr.im;
      end
   end

   assign b_re = rre_ff[tok_in.k];
   assign b_im = rim_ff[tok_in.k];

   // Stage one: the four partial products, and the token moves on.
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.a_re    <= tok_in.a_re;
      tok_ff.a_im    <= tok_in.a_im;
      tok_ff.k       <= tok_in.k;
      tok_ff.row     <= tok_in.row;
      tok_ff.first   <= tok_in.first;
      tok_ff.lastk   <= tok_in.lastk;
      tok_ff.lastrow <= tok_in.lastrow;
      p_rr_ff <= tok_in.a_re * b_re;
      p_ii_ff <= tok_in.a_im * b_im;
      p_ri_ff <= tok_in.a_re * b_im;
      p_ir_ff <= tok_in.a_im * b_re;
   end

   // The token stops at the last product column of the run, so none is left
   // in the row of cells once the run ends.
   always_comb begin
      tok_out       = tok_ff;
      tok_out.valid = tok_ff.valid && (col_id < nc_m1);
   end

   // Stage two: complex term added to the accumulator with saturation.
   always_comb begin
      term_re = 33'(p_rr_ff) - 33'(p_ii_ff);
      term_im = 33'(p_ri_ff) + 33'(p_ir_ff);
      base_re = tok_ff.first ? '0 : acc_re_ff;
      base_im = tok_ff.first ? '0 : acc_im_ff;
      sum_re  = 41'(base_re) + 41'(term_re);
      sum_im  = 41'(base_im) + 41'(term_im);
      if (sum_re[ACC_W] != sum_re[ACC_W-1]) begin
         acc_re_in = sum_re[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_re_in = sum_re[ACC_W-1:0];
      end
      if (sum_im[ACC_W] != sum_im[ACC_W-1]) begin
         acc_im_in = sum_im[ACC_W] ? ACC_MIN : ACC_MAX;
      end else begin
         acc_im_in = sum_im[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_re_ff <= '0;
         acc_im_ff <= '0;
         done_ff   <= 1'b0;
      end else begin
         if (tok_ff.valid) begin
            acc_re_ff <= acc_re_in;
            acc_im_ff <= acc_im_in;
         end
         done_ff <= tok_ff.valid && tok_ff.lastk && (col_id <= nc_m1);
      end
      row_ff  <= tok_ff.row;
      last_ff <= tok_ff.lastrow && (col_id == nc_m1);
   end

   assign done         = done_ff;
   assign res.out_row  = row_ff;
   assign res.out_col  = col_id;
   assign res.prod_re  = acc_re_ff;
   assign res.prod_im  = acc_im_ff;
   assign res.out_last = last_ff;

endmodule

### hw/rtl/cmm_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cmm_seq import cmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_acc,
   input  req_type          req,
   input  logic [DIM_W-1:0] left_rows,
   input  logic [DIM_W-1:0] inner_size,
   input  logic [DIM_W-1:0] right_cols,
   input  logic             last_done,
   output logic             busy,
   output logic [IDX_W-1:0] nc_m1,
   output tok_type          tok
);

   typedef enum logic [1:0] {IDLE, RUN, DRAIN} state_type;

   logic [31:0] left_mem [MAX_DIM*MAX_DIM];

   state_type state_ff;
   logic [IDX_W-1:0] i_ff, c_ff;
   logic [IDX_W-1:0] nr_m1_ff, nk_m1_ff, nc_m1_ff, span_m1_ff;
   tok_type tok_ff;
   logic issue;
   logic [IDX_W-1:0] nk_new, nc_new;

   assign nk_new = dim_m1(inner_size);
   assign nc_new = dim_m1(right_cols);
   assign issue  = (state_ff == RUN) && (c_ff <= nk_m1_ff);

   // Left store: written on each left load, read one element a cycle.
   always_ff @(posedge clock) begin
      if (req_acc && req.func == FUNC_LEFT) begin
         left_mem[{req.row_index, req.col_index}] <= {req.value_im, req.value_re};
      end
   end

   // Run control: one left element per cycle for each product row, rows
   // spaced far enough apart that the cells never finish at the same time.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         i_ff         <= '0;
         c_ff         <= '0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= issue;
         case (state_ff)
            IDLE: begin
               if (req_acc && req.load_last) begin
                  state_ff   <= RUN;
                  i_ff       <= '0;
                  c_ff       <= '0;
                  nr_m1_ff   <= dim_m1(left_rows);
                  nk_m1_ff   <= nk_new;
                  nc_m1_ff   <= nc_new;
                  span_m1_ff <= (nk_new > nc_new) ? nk_new : nc_new;
               end
            end
            RUN: begin
               if (c_ff == span_m1_ff) begin
                  c_ff <= '0;
                  if (i_ff == nr_m1_ff) begin
                     state_ff <= DRAIN;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  c_ff <= c_ff + 1'b1;
               end
            end
            DRAIN: begin
               if (last_done) begin
                  state_ff <= IDLE;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
      {tok_ff.a_im, tok_ff.a_re} <= left_mem[{i_ff, c_ff}];
      tok_ff.k       <= c_ff;
      tok_ff.row     <= i_ff;
      tok_ff.first   <= (c_ff == '0);
      tok_ff.lastk   <= (c_ff == nk_m1_ff);
      tok_ff.lastrow <= (i_ff == nr_m1_ff);
   end

   assign tok   = tok_ff;
   assign busy  = (state_ff != IDLE);
   assign nc_m1 = nc_m1_ff;

   `ASSERT_CLK(a_start_busy, clock, reset, (req_acc && req.load_last) |=> busy, "run did not start")
   `ASSERT_NEVER(a_issue_idle, clock, reset, tok_ff.valid && !busy && !$past(busy), "token while idle")
   `ASSERT_CLK(a_done_drain, clock, reset, last_done |-> (state_ff == DRAIN), "last result outside drain")

endmodule

### hw/rtl/complex_matrix_multiply.sv
`timescale 1ns / 1ps
// One result per cycle within each product row, one left element per cycle.
// Loads are taken one per cycle while busy is low; busy is high for the whole run.
// Reset (synchronous, active high) sets every dimension to 8 and stops any run.
// Results are strobed for one cycle each; the receiver cannot stall.
`include "assert_macros.svh"
module complex_matrix_multiply import cmm_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   logic [DIM_W-1:0] left_rows_ff, inner_size_ff, right_cols_ff;
   logic req_acc;
   logic [IDX_W-1:0] nc_m1;
   tok_type tok_w [MAX_DIM+1];
   logic [MAX_DIM-1:0] done_w;
   rsp_type res_w [MAX_DIM];
   rwr_type rwr;

   assign req_acc = start && !busy;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_rows_ff  <= DIM_W'(MAX_DIM);
         inner_size_ff <= DIM_W'(MAX_DIM);
         right_cols_ff <= DIM_W'(MAX_DIM);
      end else if (csr_we) begin
         case (csr_index)
            CSR_LEFT_ROWS:  left_rows_ff  <= csr_wdata;
            CSR_INNER_SIZE: inner_size_ff <= csr_wdata;
            CSR_RIGHT_COLS: right_cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rwr.en  = req_acc && req_data.func == FUNC_RIGHT;
   assign rwr.row = req_data.row_index;
   assign rwr.col = req_data.col_index;
   assign rwr.re  = req_data.value_re;
   assign rwr.im  = req_data.value_im;

   cmm_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_acc    (req_acc),
      .req        (req_data),
      .left_rows  (left_rows_ff),
      .inner_size (inner_size_ff),
      .right_cols (right_cols_ff),
      .last_done  (rsp_valid && rsp_data.out_last),
      .busy       (busy),
      .nc_m1      (nc_m1),
      .tok        (tok_w[0])
   );

   // Row of cells, one per product column.
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      cmm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .col_id  (IDX_W'(j)),
         .nc_m1   (nc_m1),
         .rwr     (rwr),
         .tok_in  (tok_w[j]),
         .tok_out (tok_w[j+1]),
         .done    (done_w[j]),
         .res     (res_w[j])
      );
   end

   // Cells finish on distinct cycles, so the results merge by OR.
   always_comb begin
      rsp_data = '0;
      for (int j = 0; j < MAX_DIM; j++) begin
         if (done_w[j]) begin
            rsp_data = rsp_data | res_w[j];
         end
      end
   end

   assign rsp_valid = |done_w;

   `ASSERT_CLK(a_one_done, clock, reset, $onehot0(done_w), "two cells finished together")
   `ASSERT_CLK(a_rsp_busy, clock, reset, rsp_valid |-> busy, "result while idle")
   `ASSERT_CLK(a_end_idle, clock, reset, (rsp_valid && rsp_data.out_last) |=> !busy, "run did not end")

endmodule
